### sv/vpa_pkg.sv
// Shared types and constants for the variable partition allocator.
// No dependencies.
`timescale 1ns / 1ps
package vpa_pkg;
	localparam int MEM_UNITS = 1024;
	localparam int MAX_SEG   = 16;
	localparam int IDX_W     = $clog2(MAX_SEG);
	localparam int CNT_W     = $clog2(MAX_SEG + 1);
	localparam int ADDR_W    = 10;
	localparam int LEN_W     = 11;
	localparam int TASK_W    = 16;

	localparam logic CFG_FIT_MODE = 1'b0;
	localparam logic CFG_MIN_FRAG = 1'b1;

	localparam logic [LEN_W-1:0] MIN_FRAG_RST = LEN_W'(5);

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_NO_FIT     = 3'd1,
		ST_NOT_FOUND  = 3'd2,
		ST_TABLE_FULL = 3'd3,
		ST_BAD_SIZE   = 3'd4
	} status_t;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} command_t;

	typedef struct packed {
		logic              command;
		logic [TASK_W-1:0] task_id;
		logic [LEN_W-1:0]  req_size;
	} in_item_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [ADDR_W-1:0] base_addr;
		logic [LEN_W-1:0]  granted_size;
	} out_item_t;

	typedef enum logic [2:0] {
		S_IDLE, S_SCAN, S_ALLOC, S_CLEAR, S_COMPACT, S_FLUSH, S_FIN
	} state_t;

	typedef struct packed {
		logic latch;
		logic scan;
		logic alloc;
		logic clear;
		logic compact;
		logic flush;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic scan_last;
		logic free_found;
		logic is_free;
		logic out_free;
	} dp_stat_t;
endpackage

### sv/vpa_ctrl.sv
// Sequencer for allocate and free transactions.
// Depends on vpa_pkg.
`timescale 1ns / 1ps
module vpa_ctrl import vpa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.is_free) begin
					state_d = S_CLEAR;
				end else begin
					cmd.scan = 1'b1;
					if (stat.scan_last) state_d = S_ALLOC;
				end
			end
			S_ALLOC: begin
				cmd.alloc = 1'b1;
				state_d   = S_FIN;
			end
			S_CLEAR: begin
				cmd.clear = 1'b1;
				state_d   = stat.free_found ? S_COMPACT : S_FIN;
			end
			S_COMPACT: begin
				cmd.compact = 1'b1;
				if (stat.scan_last) state_d = S_FLUSH;
			end
			S_FLUSH: begin
				cmd.flush = 1'b1;
				state_d   = S_FIN;
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

### sv/vpa_dp.sv
// Segment table, scan/compaction datapath, config and output registers.
// Depends on vpa_pkg.
`timescale 1ns / 1ps
module vpa_dp import vpa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  in_item_t         in_data,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [LEN_W-1:0] cfg_data,
	input  logic             out_stall,
	output logic             out_valid,
	output out_item_t        out_data,
	input  ctrl_cmd_t        cmd,
	output dp_stat_t         stat
);
	logic [ADDR_W-1:0] start_q [MAX_SEG];
	logic [LEN_W-1:0]  len_q   [MAX_SEG];
	logic              busy_q  [MAX_SEG];
	logic [TASK_W-1:0] owner_q [MAX_SEG];
	logic [CNT_W-1:0]  count_q;

	logic              fit_q;
	logic [LEN_W-1:0]  minfrag_q;
	in_item_t          req_q;
	logic [IDX_W-1:0]  idx_q;
	logic [CNT_W-1:0]  j_q;
	logic              found_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [LEN_W-1:0]  best_len_q;
	logic [ADDR_W-1:0] best_start_q;
	// compaction accumulator: entry not yet written back
	logic [ADDR_W-1:0] acc_start_q;
	logic [LEN_W-1:0]  acc_len_q;
	logic              acc_busy_q;
	logic [TASK_W-1:0] acc_owner_q;
	out_item_t         res_q;
	out_item_t         out_q;
	logic              out_valid_q;

	logic              cand, take, split, full, merge;
	logic [MAX_SEG-1:0] match;
	logic [IDX_W-1:0]  wr_idx;

	always_comb begin
		for (int k = 0; k < MAX_SEG; k++)
			match[k] = (CNT_W'(k) < count_q) && busy_q[k] && owner_q[k] == req_q.task_id;
	end

	assign cand  = !busy_q[idx_q] && len_q[idx_q] >= req_q.req_size;
	assign take  = cand && (!found_q || (fit_q && len_q[idx_q] < best_len_q));
	assign split = (best_len_q - req_q.req_size) > minfrag_q;
	assign full  = count_q == CNT_W'(MAX_SEG);
	assign merge = (j_q != '0) && !acc_busy_q && !busy_q[idx_q];
	assign wr_idx = IDX_W'(j_q - CNT_W'(1));

	assign stat.scan_last  = {1'b0, idx_q} == count_q - CNT_W'(1);
	assign stat.free_found = |match;
	assign stat.is_free    = req_q.command == CMD_FREE;
	assign stat.out_free   = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_q       <= 1'b0;
			minfrag_q   <= MIN_FRAG_RST;
			out_valid_q <= 1'b0;
			count_q     <= CNT_W'(1);
			for (int k = 0; k < MAX_SEG; k++) begin
				start_q[k] <= '0;
				len_q[k]   <= (k == 0) ? LEN_W'(MEM_UNITS) : '0;
				busy_q[k]  <= 1'b0;
				owner_q[k] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_FIT_MODE: fit_q     <= cfg_data[0];
					CFG_MIN_FRAG: minfrag_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load_out) begin
				out_q       <= res_q;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (cmd.latch) begin
				req_q   <= in_data;
				idx_q   <= '0;
				found_q <= 1'b0;
			end

			if (cmd.scan) begin
				if (take) begin
					found_q      <= 1'b1;
					best_idx_q   <= idx_q;
					best_len_q   <= len_q[idx_q];
					best_start_q <= start_q[idx_q];
				end
				idx_q <= idx_q + IDX_W'(1);
			end

			if (cmd.alloc) begin
				if (req_q.req_size == '0) begin
					res_q <= '{ST_BAD_SIZE, '0, '0};
				end else if (!found_q) begin
					res_q <= '{ST_NO_FIT, '0, '0};
				end else if (split && full) begin
					res_q <= '{ST_TABLE_FULL, '0, '0};
				end else begin
					res_q <= '{ST_OK, best_start_q, split ? req_q.req_size : best_len_q};
					for (int k = 0; k < MAX_SEG; k++) begin
						if (IDX_W'(k) == best_idx_q) begin
							busy_q[k]  <= 1'b1;
							owner_q[k] <= req_q.task_id;
							if (split) len_q[k] <= req_q.req_size;
						end else if (split && k > 0) begin
							if (IDX_W'(k - 1) == best_idx_q) begin
								start_q[k] <= ADDR_W'(best_start_q + req_q.req_size);
								len_q[k]   <= best_len_q - req_q.req_size;
								busy_q[k]  <= 1'b0;
								owner_q[k] <= '0;
							end else if (IDX_W'(k) > best_idx_q && CNT_W'(k) <= count_q) begin
								start_q[k] <= start_q[k-1];
								len_q[k]   <= len_q[k-1];
								busy_q[k]  <= busy_q[k-1];
								owner_q[k] <= owner_q[k-1];
							end
						end
					end
					if (split) count_q <= count_q + CNT_W'(1);
				end
			end

			if (cmd.clear) begin
				for (int k = 0; k < MAX_SEG; k++) begin
					if (match[k]) begin
						busy_q[k]  <= 1'b0;
						owner_q[k] <= '0;
					end
				end
				idx_q <= '0;
				j_q   <= '0;
				if (!(|match)) res_q <= '{ST_NOT_FOUND, '0, '0};
			end

			if (cmd.compact) begin
				if (merge) begin
					acc_len_q <= acc_len_q + len_q[idx_q];
				end else begin
					if (j_q != '0) begin
						start_q[wr_idx] <= acc_start_q;
						len_q[wr_idx]   <= acc_len_q;
						busy_q[wr_idx]  <= acc_busy_q;
						owner_q[wr_idx] <= acc_owner_q;
					end
					acc_start_q <= start_q[idx_q];
					acc_len_q   <= len_q[idx_q];
					acc_busy_q  <= busy_q[idx_q];
					acc_owner_q <= owner_q[idx_q];
					j_q         <= j_q + CNT_W'(1);
				end
				idx_q <= idx_q + IDX_W'(1);
			end

			if (cmd.flush) begin
				start_q[wr_idx] <= acc_start_q;
				len_q[wr_idx]   <= acc_len_q;
				busy_q[wr_idx]  <= acc_busy_q;
				owner_q[wr_idx] <= acc_owner_q;
				count_q         <= j_q;
				res_q           <= '{ST_OK, '0, '0};
			end
		end
	end
endmodule

### sv/variable_partition_allocator.sv
// Variable partition allocator: one transaction at a time, N = segments in use (1..16).
// Allocate: result valid after accept, N-entry scan, table update and output load.
// Free: decode, owner clear, N-entry compaction, flush, load; unknown task skips compaction.
// Next transaction is accepted once the result is loaded; an output stall holds the load.
// Reset (arst_n low, async): one free segment of 1024 units, first fit, min fragment 5.
// Depends on vpa_pkg, vpa_ctrl, vpa_dp.
`timescale 1ns / 1ps
module variable_partition_allocator import vpa_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_item_t        out_data,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [LEN_W-1:0] cfg_data
);
	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// controller: walks scan / update / compaction steps per transaction
	vpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: segment table, config, pending result and output register
	vpa_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.stat      (stat)
	);
endmodule

### sv/vpa_checker.sv
// Port-level checks for the variable partition allocator, bound to the top level.
// Depends on vpa_pkg.
`timescale 1ns / 1ps
module vpa_checker import vpa_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transaction accepted while busy");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.status <= ST_BAD_SIZE)
		else $error("bad status code");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |->
			out_data.base_addr == '0 && out_data.granted_size == '0)
		else $error("failed transaction carries nonzero fields");
endmodule

bind variable_partition_allocator vpa_checker u_vpa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
